/* hw/rtl/scoped_symbol_table_macros.svh */
// Assertion macros shared by the scoped symbol table RTL.
`ifndef SCOPED_SYMBOL_TABLE_MACROS_SVH
`define SCOPED_SYMBOL_TABLE_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge of clk outside reset.
`define SST_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("scoped_symbol_table: assertion failed");
// Check that an expression never holds outside reset.
`define SST_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("scoped_symbol_table: forbidden condition seen");
`else
`define SST_ASSERT(lbl, prop)
`define SST_NEVER(lbl, expr)
`endif

`endif

/* hw/rtl/sst_pkg.sv */
// Types and constants of the scoped symbol table.
package sst_pkg;

	localparam int ID_W      = 16;
	localparam int TYPE_W    = 16;
	localparam int OUT_LVL_W = 4;
	localparam int CMD_W     = 3;
	localparam int STATUS_W  = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_CREATE = 3'd0,
		CMD_LOOKUP = 3'd1,
		CMD_ENTER  = 3'd2,
		CMD_LEAVE  = 3'd3,
		CMD_CLEAR  = 3'd4
	} cmd_t;

	localparam logic [STATUS_W-1:0] STS_OK           = 2'd0;
	localparam logic [STATUS_W-1:0] STS_LEAVE_GLOBAL = 2'd1;
	localparam logic [STATUS_W-1:0] STS_FULL         = 2'd2;
	localparam logic [STATUS_W-1:0] STS_DEPTH        = 2'd3;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_SCAN,
		S_WRITE,
		S_CLEAR,
		S_RESP
	} state_t;

endpackage

/* hw/rtl/sst_table.sv */
// Entry store of the scoped symbol table: one write port, one registered read port.
module sst_table #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 37
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* hw/rtl/scoped_symbol_table.sv */
// Scoped symbol table: sequencer, scan compare unit and result register.
// Commands: create scans the entry store and then writes its entry, lookup and leave scan
// it, clear sweeps it; enter, leave at global and unknown commands go straight to the result.
// One command at a time; the linear scan over the entry store makes one read per cycle
// on its single read port.
// Reset: arst_n clears control state at once; a clearing pass then sweeps every entry of
// the store, during which no command is taken.
`include "scoped_symbol_table_macros.svh"

module scoped_symbol_table #(
	parameter int TABLE_ENTRIES = 64,
	parameter int MAX_LEVEL     = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	// command channel
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] var_type, [31:16] var_id
	input  logic [2:0]  s_tuser,   // [2:0] cmd
	// result channel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [15:0] result_id, [16] found, [32:17] result_type,
	                               // [36:33] result_level, [40:37] level_now, rest zero
	output logic [1:0]  m_tuser    // [1:0] status
);

	import sst_pkg::*;

	localparam int AW     = $clog2(TABLE_ENTRIES);
	localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
	localparam int LVL_W  = $clog2(MAX_LEVEL + 1);
	localparam int WORD_W = 1 + LVL_W + TYPE_W + ID_W;
	localparam int PAD_W  = 48 - (ID_W + 1 + TYPE_W + 2 * OUT_LVL_W);

	// Sequencer and scan state
	state_t             state_q, state_d;
	logic [CNT_W-1:0]   cnt_q;
	logic               vld_s1;
	logic [AW-1:0]      idx_s1;

	// Architectural state
	logic [LVL_W-1:0]   depth_q;
	logic [ID_W-1:0]    next_id_q;

	// Latched command
	cmd_t               cmd_q;
	logic [TYPE_W-1:0]  type_q;
	logic [ID_W-1:0]    vid_q;

	// Result being built
	logic [ID_W-1:0]    res_id_q;
	logic               res_found_q;
	logic [TYPE_W-1:0]  res_type_q;
	logic [LVL_W-1:0]   res_level_q;
	logic [STATUS_W-1:0] res_status_q;

	// Slot choice for create
	logic               hit_q, free_ok_q;
	logic [AW-1:0]      hit_idx_q, free_idx_q;

	// Output register
	logic               m_tvalid_q;
	logic [47:0]        m_tdata_q;
	logic [1:0]         m_tuser_q;

	// Store ports
	logic               wr_en, rd_en;
	logic [AW-1:0]      wr_addr, rd_addr;
	logic [WORD_W-1:0]  wr_data, rd_data;

	// Fields of the entry read in the previous cycle
	logic               e_valid;
	logic [LVL_W-1:0]   e_lvl;
	logic [TYPE_W-1:0]  e_type;
	logic [ID_W-1:0]    e_id;

	logic               accept, out_free, scan_last, wipe_last;
	logic               create_hit, create_free, look_hit, leave_kill, slot_ok;
	logic [AW-1:0]      slot_idx;
	logic [LVL_W+OUT_LVL_W-1:0] lvl_now_ext, lvl_res_ext;

	assign accept   = s_tvalid && s_tready;
	// The result register can take a new transaction when empty or being drained
	assign out_free = !m_tvalid_q || m_tready;

	assign {e_valid, e_lvl, e_type, e_id} = rd_data;

	// Shared compare unit: one entry per cycle against the latched command
	assign create_hit  = vld_s1 && e_valid && !hit_q && (e_id == next_id_q) &&
	                     (e_lvl == depth_q);
	assign create_free = vld_s1 && !e_valid && !free_ok_q;
	assign look_hit    = vld_s1 && e_valid && (e_id == vid_q) && (e_lvl <= depth_q) &&
	                     (!res_found_q || (e_lvl > res_level_q));
	assign leave_kill  = vld_s1 && e_valid && (e_lvl == depth_q);

	assign scan_last = vld_s1 && (idx_s1 == AW'(TABLE_ENTRIES - 1));
	assign wipe_last = (cnt_q == CNT_W'(TABLE_ENTRIES - 1));

	// Prefer the slot already holding this id at this level, else the lowest free one
	assign slot_ok  = hit_q || free_ok_q;
	assign slot_idx = hit_q ? hit_idx_q : free_idx_q;

	// Widen before truncating so the 4-bit level fields work for any level width
	assign lvl_now_ext = {{OUT_LVL_W{1'b0}}, depth_q};
	assign lvl_res_ext = {{OUT_LVL_W{1'b0}}, res_level_q};

	sst_table #(
		.DEPTH (TABLE_ENTRIES),
		.WIDTH (WORD_W)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT: begin
				if (wipe_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					unique case (s_tuser) inside
						CMD_CREATE, CMD_LOOKUP: state_d = S_SCAN;
						CMD_LEAVE:  state_d = (depth_q == '0) ? S_RESP : S_SCAN;
						CMD_CLEAR:  state_d = S_CLEAR;
						default:    state_d = S_RESP;
					endcase
				end
			end
			S_SCAN: begin
				if (scan_last) state_d = (cmd_q == CMD_CREATE) ? S_WRITE : S_RESP;
			end
			S_WRITE: state_d = S_RESP;
			S_CLEAR: begin
				if (wipe_last) state_d = S_RESP;
			end
			S_RESP: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_INIT;
		endcase
	end

	// Store port and handshake drive
	always_comb begin
		s_tready = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = cnt_q[AW-1:0];
		wr_en    = 1'b0;
		wr_addr  = cnt_q[AW-1:0];
		wr_data  = '0;
		unique case (state_q)
			S_INIT, S_CLEAR: begin
				// sweep: drop every entry, one per cycle
				wr_en = 1'b1;
			end
			S_IDLE: s_tready = 1'b1;
			S_SCAN: begin
				rd_en = (cnt_q < CNT_W'(TABLE_ENTRIES));
				if (cmd_q == CMD_LEAVE && leave_kill) begin
					// invalidate the entry just compared, behind the read pointer
					wr_en   = 1'b1;
					wr_addr = idx_s1;
				end
			end
			S_WRITE: begin
				wr_en   = slot_ok;
				wr_addr = slot_idx;
				wr_data = {1'b1, depth_q, type_q, next_id_q};
			end
			S_RESP: ;
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			cnt_q        <= '0;
			vld_s1       <= 1'b0;
			depth_q      <= '0;
			next_id_q    <= ID_W'(1);
			hit_q        <= 1'b0;
			free_ok_q    <= 1'b0;
			res_found_q  <= 1'b0;
			res_status_q <= STS_OK;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			// Advance the compare pipe only while the scan still has entries to read
			vld_s1  <= (state_q == S_SCAN) && (cnt_q < CNT_W'(TABLE_ENTRIES));
			// Raise the result on the response step, drop it once the transaction completes
			if (state_q == S_RESP && out_free) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			unique case (state_q)
				S_INIT: cnt_q <= cnt_q + CNT_W'(1);
				S_IDLE: begin
					if (accept) begin
						cnt_q       <= '0;
						hit_q       <= 1'b0;
						free_ok_q   <= 1'b0;
						res_found_q <= 1'b0;
						// hold the level at the deepest scope
						if (s_tuser == CMD_ENTER && depth_q >= LVL_W'(MAX_LEVEL))
							res_status_q <= STS_DEPTH;
						else if (s_tuser == CMD_LEAVE && depth_q == '0)
							res_status_q <= STS_LEAVE_GLOBAL;
						else
							res_status_q <= STS_OK;
						if (s_tuser == CMD_ENTER && depth_q < LVL_W'(MAX_LEVEL))
							depth_q <= depth_q + LVL_W'(1);
					end
				end
				S_SCAN: begin
					if (cnt_q < CNT_W'(TABLE_ENTRIES)) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (cmd_q == CMD_CREATE) begin
						if (create_hit) hit_q <= 1'b1;
						if (create_free) free_ok_q <= 1'b1;
					end
					if (cmd_q == CMD_LOOKUP && look_hit) res_found_q <= 1'b1;
					if (cmd_q == CMD_LEAVE && scan_last) depth_q <= depth_q - LVL_W'(1);
				end
				S_WRITE: begin
					if (slot_ok) next_id_q <= next_id_q + ID_W'(1);
					else res_status_q <= STS_FULL;
				end
				S_CLEAR: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (wipe_last) begin
						depth_q   <= '0;
						next_id_q <= ID_W'(1);
					end
				end
				S_RESP: ;
				default: ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_q       <= cmd_t'(s_tuser);
					type_q      <= s_tdata[15:0];
					vid_q       <= s_tdata[31:16];
					res_id_q    <= '0;
					res_type_q  <= '0;
					res_level_q <= '0;
				end
			end
			S_SCAN: begin
				idx_s1 <= cnt_q[AW-1:0];
				if (cmd_q == CMD_CREATE && create_hit) hit_idx_q <= idx_s1;
				if (cmd_q == CMD_CREATE && create_free) free_idx_q <= idx_s1;
				if (cmd_q == CMD_LOOKUP && look_hit) begin
					res_id_q    <= e_id;
					res_type_q  <= e_type;
					res_level_q <= e_lvl;
				end
			end
			S_WRITE: begin
				if (slot_ok) res_id_q <= next_id_q;
			end
			S_RESP: begin
				if (out_free) begin
					m_tdata_q <= {{PAD_W{1'b0}}, lvl_now_ext[OUT_LVL_W-1:0],
					              lvl_res_ext[OUT_LVL_W-1:0], res_type_q, res_found_q,
					              res_id_q};
					m_tuser_q <= res_status_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// One command at a time: a transaction closes the command port for the next cycle
	`SST_ASSERT(a_one_cmd, (s_tvalid && s_tready) |=> !s_tready)
	// The store is never written while waiting for a command
	`SST_NEVER(a_no_idle_write, wr_en && state_q == S_IDLE)
	// The scope level stays within the deepest allowed scope
	`SST_ASSERT(a_depth_bound, depth_q <= LVL_W'(MAX_LEVEL))
	// A result only appears from the response step
	`SST_ASSERT(a_resp_source, $rose(m_tvalid_q) |-> $past(state_q) == S_RESP)
	// Compared entries only arrive during a scan
	`SST_ASSERT(a_scan_pipe, vld_s1 |-> state_q == S_SCAN)

endmodule
